// ===== hw/rtl/zip_traditional_stream_decryptor_macros.svh =====
// assertion macros for the zip traditional stream decryptor
// used by the top level only, no other dependencies
`ifndef ZIP_TRADITIONAL_STREAM_DECRYPTOR_MACROS_SVH
`define ZIP_TRADITIONAL_STREAM_DECRYPTOR_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, disabled in reset
`define ZTSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, disabled in reset
`define ZTSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ZTSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ZTSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/ztsd_pkg.sv =====
// shared types, command codes, key constants and crc/keystream functions
// no dependencies
`timescale 1ns / 1ps

package ztsd_pkg;

  localparam logic [1:0] CMD_RESET   = 2'd0;
  localparam logic [1:0] CMD_ABSORB  = 2'd1;
  localparam logic [1:0] CMD_DECRYPT = 2'd2;

  localparam logic [31:0] KEY_ZERO_INIT = 32'h12345678;
  localparam logic [31:0] KEY_ONE_INIT  = 32'h23456789;
  localparam logic [31:0] KEY_TWO_INIT  = 32'h34567890;
  localparam logic [31:0] LCG_MULT      = 32'd134775813;
  localparam logic [31:0] CRC_POLY      = 32'hEDB88320;

  // stage strobes from the controller to the datapath
  typedef struct packed {
    logic load;   // item accepted: first key stage
    logic mul;    // lcg multiply stage
    logic fin;    // last key stage, result into output register
  } ctrl_t;

  // reflected crc-32 table entry, folds to a constant rom
  function automatic logic [31:0] crc_entry(input logic [7:0] idx);
    logic [31:0] v;
    v = {24'd0, idx};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    return crc_entry(c[7:0] ^ b) ^ {8'd0, c[31:8]};
  endfunction

  // keystream byte from the low half of key two
  function automatic logic [7:0] ks_byte(input logic [31:0] k2);
    logic [15:0] t;
    logic [31:0] p;
    t = k2[15:0] | 16'd2;
    p = {16'd0, t} * {16'd0, t ^ 16'd1};
    return p[15:8];
  endfunction

  localparam logic [7:0] KS_INIT = ks_byte(KEY_TWO_INIT);

endpackage

// ===== hw/rtl/ztsd_ctrl.sv =====
// controller state machine: handshakes and stage strobes
// depends on ztsd_pkg
`timescale 1ns / 1ps

module ztsd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output ztsd_pkg::ctrl_t ctrl
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ctrl.load = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        ctrl.mul  = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // wait here while a finished result is still unread
        if (out_free) begin
          ctrl.fin  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/ztsd_dp.sv =====
// datapath: the three keys, keystream byte and the output register
// depends on ztsd_pkg
`timescale 1ns / 1ps

module ztsd_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  ztsd_pkg::ctrl_t ctrl,
  input  logic [1:0]      cmd,
  input  logic [7:0]      data_byte,
  input  logic [7:0]      check_byte,
  output logic [7:0]      out_byte,
  output logic            check_ok
);

  logic [31:0] key0_r, key0_nxt;
  logic [31:0] key1_r, key1_nxt;
  logic [31:0] key2_r, key2_nxt;
  logic [7:0]  ks_r, ks_nxt;
  logic        mix_r, mix_nxt;     // item updates keys through mul/fin
  logic [7:0]  plain_r, plain_nxt;
  logic        ok_r, ok_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        check_ok_r, check_ok_nxt;

  logic [7:0]  plain;
  logic [7:0]  mix_byte;
  logic [31:0] key2_crc;

  assign plain    = data_byte ^ ks_r;
  assign mix_byte = (cmd == ztsd_pkg::CMD_DECRYPT) ? plain : data_byte;
  assign key2_crc = ztsd_pkg::crc_step(key2_r, key1_r[31:24]);

  always_comb begin
    key0_nxt     = key0_r;
    key1_nxt     = key1_r;
    key2_nxt     = key2_r;
    ks_nxt       = ks_r;
    mix_nxt      = mix_r;
    plain_nxt    = plain_r;
    ok_nxt       = ok_r;
    out_byte_nxt = out_byte_r;
    check_ok_nxt = check_ok_r;
    if (ctrl.load) begin
      mix_nxt   = 1'b0;
      plain_nxt = 8'd0;
      ok_nxt    = 1'b0;
      case (cmd)
        ztsd_pkg::CMD_RESET: begin
          key0_nxt = ztsd_pkg::KEY_ZERO_INIT;
          key1_nxt = ztsd_pkg::KEY_ONE_INIT;
          key2_nxt = ztsd_pkg::KEY_TWO_INIT;
          ks_nxt   = ztsd_pkg::KS_INIT;
        end
        ztsd_pkg::CMD_ABSORB: begin
          key0_nxt = ztsd_pkg::crc_step(key0_r, mix_byte);
          mix_nxt  = 1'b1;
        end
        ztsd_pkg::CMD_DECRYPT: begin
          key0_nxt  = ztsd_pkg::crc_step(key0_r, mix_byte);
          mix_nxt   = 1'b1;
          plain_nxt = plain;
          ok_nxt    = (plain == check_byte);
        end
        default: begin
          // unused code leaves the keys alone
        end
      endcase
    end
    if (ctrl.mul && mix_r) begin
      key1_nxt = (key1_r + {24'd0, key0_r[7:0]}) * ztsd_pkg::LCG_MULT + 32'd1;
    end
    if (ctrl.fin) begin
      if (mix_r) begin
        key2_nxt = key2_crc;
        ks_nxt   = ztsd_pkg::ks_byte(key2_crc);
      end
      out_byte_nxt = plain_r;
      check_ok_nxt = ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= ztsd_pkg::KEY_ZERO_INIT;
      key1_r <= ztsd_pkg::KEY_ONE_INIT;
      key2_r <= ztsd_pkg::KEY_TWO_INIT;
      ks_r   <= ztsd_pkg::KS_INIT;
      mix_r  <= 1'b0;
    end else begin
      key0_r <= key0_nxt;
      key1_r <= key1_nxt;
      key2_r <= key2_nxt;
      ks_r   <= ks_nxt;
      mix_r  <= mix_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plain_r    <= plain_nxt;
    ok_r       <= ok_nxt;
    out_byte_r <= out_byte_nxt;
    check_ok_r <= check_ok_nxt;
  end

  assign out_byte = out_byte_r;
  assign check_ok = check_ok_r;

endmodule

// ===== hw/rtl/zip_traditional_stream_decryptor.sv =====
// top level of the traditional zip stream decryptor
// depends on ztsd_pkg, ztsd_ctrl, ztsd_dp and the assertion macro header
`timescale 1ns / 1ps
//
// usage:
//   input stream: one transaction per command. in_tuser carries the command
//   (reset keys, absorb password byte, decrypt cipher byte); in_tdata carries
//   the data byte and the check byte.
//   output stream: exactly one transaction per input transaction, in order.
//   out_tdata is the plain byte (zero unless decrypt), out_tuser the check
//   flag (plain byte equals the check byte, decrypt only).
// stages:
//   the key recurrence allows one item in flight: a new item is accepted
//   only after the last one has left the last stage. the first stage does
//   keystream xor and the key zero crc, the second the lcg multiply on key
//   one, the third the key two crc plus the next keystream multiply.
//   out_tvalid rises once the last stage has loaded the output register.
// reset and stall:
//   rst_n low loads the three initial keys and empties the output register.
//   the output register holds a result while the receiver stalls; the next
//   item is still accepted and worked on, and only its last stage waits
//   until the held result is taken.
//
`include "zip_traditional_stream_decryptor_macros.svh"

module zip_traditional_stream_decryptor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [15:8] check_byte
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [0:0]  out_tuser   // [0] check_ok
);

  ztsd_pkg::ctrl_t ctrl;
  logic            check_ok;

  // handshakes and stage sequencing
  ztsd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctrl       (ctrl)
  );

  // keys, keystream and result register
  ztsd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .cmd        (in_tuser),
    .data_byte  (in_tdata[7:0]),
    .check_byte (in_tdata[15:8]),
    .out_byte   (out_tdata),
    .check_ok   (check_ok)
  );

  assign out_tuser = check_ok;

  // one item in flight: no transaction right after an accepted one
  `ZTSD_ASSERT_NEXT(a_no_back_to_back, clk, rst_n, in_tvalid && in_tready, !in_tready, "input accepted twice in a row")
  // accepted item moves straight into the multiply stage
  `ZTSD_ASSERT_NEXT(a_load_then_mul, clk, rst_n, ctrl.load, ctrl.mul, "multiply stage skipped")
  // last stage always leaves a valid result behind
  `ZTSD_ASSERT_NEXT(a_fin_gives_out, clk, rst_n, ctrl.fin, out_tvalid, "result lost after last stage")
  // stage strobes are exclusive
  `ZTSD_ASSERT_IMPL(a_strobe_onehot, clk, rst_n, 1'b1, $onehot0({ctrl.load, ctrl.mul, ctrl.fin}), "stage strobes overlap")

endmodule

// ===== tb/zip_decrypt_checker.sv =====
// result checker for the zip traditional stream decryptor: watches both streams,
// predicts each result from its own key model and compares. depends on ztsd_pkg
`timescale 1ns / 1ps

module zip_decrypt_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [15:8] check_byte
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] out_byte
  input  logic [0:0]  out_tuser,  // [0] check_ok
  output int          fail_count,
  output int          pending,
  output logic [7:0]  ks_hint     // keystream byte the next decrypt will use
);

  typedef struct packed {
    logic [7:0] plain;
    logic       ok;
  } plain_res_t;

  logic [31:0] crc_tab [256];
  logic [31:0] ka = ztsd_pkg::KEY_ZERO_INIT;
  logic [31:0] kb = ztsd_pkg::KEY_ONE_INIT;
  logic [31:0] kc = ztsd_pkg::KEY_TWO_INIT;
  plain_res_t  plain_q [$];

  // reflected crc-32 table, shift and masked xor per bit
  initial begin
    logic [31:0] r;
    for (int n = 0; n < 256; n++) begin
      r = n;
      repeat (8) r = (r >> 1) ^ (ztsd_pkg::CRC_POLY & {32{r[0]}});
      crc_tab[n[7:0]] = r;
    end
  end

  function automatic logic [31:0] crc_roll(input logic [31:0] c, input logic [7:0] b);
    return crc_tab[c[7:0] ^ b] ^ (c >> 8);
  endfunction

  function automatic logic [7:0] keystream_of(input logic [31:0] k);
    logic [15:0] t;
    logic [31:0] sq;
    t  = k[15:0] | 16'h0002;
    sq = 32'(t) * 32'(t ^ 16'h0001);
    return sq[15:8];
  endfunction

  assign ks_hint = keystream_of(kc);

  always @(posedge clk) begin : predict_and_compare
    plain_res_t want;
    logic [7:0] pt;
    logic       hit;
    if (!rst_n) begin
      ka = ztsd_pkg::KEY_ZERO_INIT;
      kb = ztsd_pkg::KEY_ONE_INIT;
      kc = ztsd_pkg::KEY_TWO_INIT;
      plain_q.delete();
    end else begin
      // result side first: a result never belongs to the item accepted at the same edge
      if (out_tvalid && out_tready) begin
        if (plain_q.size() == 0) begin
          $error("unexpected result: out_byte %02h check_ok %0b", out_tdata, out_tuser[0]);
          fail_count++;
        end else begin
          want = plain_q.pop_front();
          if (out_tdata !== want.plain) begin
            $error("out_byte: expected %02h, actual %02h", want.plain, out_tdata);
            fail_count++;
          end
          if (out_tuser[0] !== want.ok) begin
            $error("check_ok: expected %0b, actual %0b", want.ok, out_tuser[0]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pt  = 8'h00;
        hit = 1'b0;
        case (in_tuser)
          ztsd_pkg::CMD_RESET: begin
            ka = ztsd_pkg::KEY_ZERO_INIT;
            kb = ztsd_pkg::KEY_ONE_INIT;
            kc = ztsd_pkg::KEY_TWO_INIT;
          end
          ztsd_pkg::CMD_ABSORB, ztsd_pkg::CMD_DECRYPT: begin
            if (in_tuser == ztsd_pkg::CMD_DECRYPT) begin
              pt  = in_tdata[7:0] ^ keystream_of(kc);
              hit = (pt == in_tdata[15:8]);
            end else begin
              pt = in_tdata[7:0];
            end
            ka = crc_roll(ka, pt);
            kb = (kb + {24'd0, ka[7:0]}) * ztsd_pkg::LCG_MULT + 32'd1;
            kc = crc_roll(kc, kb[31:24]);
            if (in_tuser == ztsd_pkg::CMD_ABSORB) pt = 8'h00;
          end
          default: ;  // unused code leaves the keys alone
        endcase
        plain_q.push_back('{plain: pt, ok: hit});
      end
    end
    pending = plain_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// top of the zip traditional stream decryptor testbench: clock, reset, stimulus and verdict
// depends on ztsd_pkg, the decryptor rtl and zip_decrypt_checker
`timescale 1ns / 1ps

module tb_top;

  // command code the block treats as a no-op
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 950;
  // idle cycles with no transaction on either side before the run is called dead;
  // the slowest correct gap is a long send gap plus a long stall plus the pass through the stages
  localparam int IDLE_LIMIT  = 4000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = 16'h0000;            // [7:0] data_byte, [15:8] check_byte
  logic [1:0]  in_tuser   = ztsd_pkg::CMD_RESET; // [1:0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;                        // [7:0] out_byte
  logic [0:0]  out_tuser;                        // [0] check_ok

  int          fail_count;
  int          pending;
  logic [7:0]  ks_hint;

  int          sent_count  = 0;
  int          idle_cycles = 0;
  bit          smooth_tx   = 1'b0;    // stretch with no send gaps
  bit          smooth_rx   = 1'b0;    // stretch with no receiver stalls
  int          stall_left  = 0;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  zip_traditional_stream_decryptor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  zip_decrypt_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending),
    .ks_hint    (ks_hint)
  );

  // gap length: mostly none, often a few cycles, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    int g;
    if ($urandom_range(0, 299) == 0) smooth_rx = !smooth_rx;
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      g = smooth_rx ? 0 : pick_gap();
      if (g > 0) begin
        out_tready <= 1'b0;
        stall_left = g - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog: counts cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("zip_traditional_stream_decryptor: mismatch");
        $finish;
      end
    end
  end

  // one input transaction: optional gap, then hold until accepted.
  // called and returns on a falling edge
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] data,
                           input logic [7:0] chk);
    int gap;
    gap = smooth_tx ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {chk, data};
    do @(posedge clk); while (!in_tready);
    sent_count++;
    @(negedge clk);
  endtask

  // decrypt whose plain byte comes out as the given value, so the check matches
  task automatic send_plain_match(input logic [7:0] plain);
    send_item(ztsd_pkg::CMD_DECRYPT, ks_hint ^ plain, plain);
  endtask

  // password entry and header check as a host does it: reset keys, absorb the
  // password, decrypt the 12 header bytes with the check on the last, then some body
  task automatic run_session(input bit good_pw, input bit skip_reset);
    int plen;
    int body;
    if (!skip_reset) send_item(ztsd_pkg::CMD_RESET, 8'($urandom), 8'($urandom));
    plen = $urandom_range(0, 12);
    repeat (plen) send_item(ztsd_pkg::CMD_ABSORB, 8'($urandom), 8'($urandom));
    repeat (11) send_item(ztsd_pkg::CMD_DECRYPT, 8'($urandom), 8'($urandom));
    if (good_pw) send_plain_match(8'($urandom));
    else         send_item(ztsd_pkg::CMD_DECRYPT, 8'($urandom), 8'($urandom));
    body = $urandom_range(0, 24);
    repeat (body) send_item(ztsd_pkg::CMD_DECRYPT, 8'($urandom), 8'($urandom));
  endtask

  initial begin
    int r;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: field extremes, every command, unused code, matching checks
    send_item(ztsd_pkg::CMD_DECRYPT, 8'h00, 8'h00);  // decrypt straight from reset keys
    send_item(ztsd_pkg::CMD_RESET,   8'hff, 8'hff);  // reset with all field bits high
    send_item(ztsd_pkg::CMD_ABSORB,  8'h00, 8'hff);
    send_item(ztsd_pkg::CMD_ABSORB,  8'hff, 8'h00);
    send_plain_match(8'h00);                          // plain byte zero, check hit
    send_plain_match(8'hff);                          // plain byte all ones, check hit
    send_item(ztsd_pkg::CMD_DECRYPT, 8'hff, 8'hff);
    send_item(ztsd_pkg::CMD_DECRYPT, 8'h00, 8'hff);
    send_item(CMD_UNUSED,            8'hff, 8'hff);  // unused code: keys untouched
    send_item(CMD_UNUSED,            8'h00, 8'h00);
    send_plain_match(8'h5a);                          // proves the unused code left the keys
    send_item(ztsd_pkg::CMD_RESET,   8'h00, 8'h00);
    send_item(ztsd_pkg::CMD_ABSORB,  8'h61, 8'h00);
    send_item(ztsd_pkg::CMD_ABSORB,  8'h62, 8'h00);
    send_item(ztsd_pkg::CMD_ABSORB,  8'h63, 8'h00);
    repeat (4) send_item(ztsd_pkg::CMD_DECRYPT, 8'($urandom), 8'($urandom));
    send_plain_match(8'ha5);

    // random part: mostly well-formed sessions, the rest noise and broken ones
    while (sent_count < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) smooth_tx = !smooth_tx;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        run_session(1'($urandom_range(0, 1)), 1'b0);
      end else if (r < 80) begin
        // broken session: no reset in front, keys carry over
        run_session(1'($urandom_range(0, 1)), 1'b1);
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
      end
    end
    in_tvalid <= 1'b0;

    // drain: every expected result in, then a few cycles for strays
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("zip_traditional_stream_decryptor: match");
    else
      $display("zip_traditional_stream_decryptor: mismatch");
    $finish;
  end

endmodule

// ===== zip_traditional_stream_decryptor.f =====
+incdir+hw/rtl
hw/rtl/ztsd_pkg.sv
hw/rtl/ztsd_ctrl.sv
hw/rtl/ztsd_dp.sv
hw/rtl/zip_traditional_stream_decryptor.sv
tb/zip_decrypt_checker.sv
tb/tb_top.sv
